// File: design/coc_pkg.sv
// ----------------------------------------------------------------------------
// coc_pkg
// Shared types and constants for the cuff occlusion controller: item words,
// op codes, register indexes, sequencer and back-end state encodings.
// ----------------------------------------------------------------------------
package coc_pkg;

   // converter sample width and the shared multiplier operand width
   localparam int SAMPLE_BITS = 24;
   localparam int MUL_W       = 32;

   // command queue between front and back
   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   // saturation limits of the converted pressure, the mmHg value and the hold count
   localparam logic [31:0] PRESS_POS_SAT = 32'h7FFF_FFFF;
   localparam logic [31:0] PRESS_NEG_SAT = 32'h8000_0000;
   localparam logic [15:0] MMHG_SAT      = 16'hFFFF;
   localparam logic [7:0]  HOLD_SAT      = 8'hFF;

   // op codes of an input word
   localparam logic [2:0] OP_SAMPLE      = 3'd0;
   localparam logic [2:0] OP_TICK        = 3'd1;
   localparam logic [2:0] OP_RUN         = 3'd2;
   localparam logic [2:0] OP_SET_PUMP    = 3'd3;
   localparam logic [2:0] OP_SET_VALVE   = 3'd4;
   localparam logic [2:0] OP_TOGGLE_PUMP = 3'd5;
   localparam logic [2:0] OP_TOGGLE_VALVE = 3'd6;

   // register indexes
   localparam logic [2:0] CSR_CONV_GAIN    = 3'd0;
   localparam logic [2:0] CSR_CONV_OFFSET  = 3'd1;
   localparam logic [2:0] CSR_MAX_PRESSURE = 3'd2;
   localparam logic [2:0] CSR_PRESSURE_CAP = 3'd3;
   localparam logic [2:0] CSR_HOLD_SECONDS = 3'd4;
   localparam logic [2:0] CSR_MMHG_FACTOR  = 3'd5;

   // reported phase codes
   localparam logic [1:0] PHASE_IDLE    = 2'd0;
   localparam logic [1:0] PHASE_INFLATE = 2'd1;
   localparam logic [1:0] PHASE_HOLD    = 2'd2;

   // command class decided by the front end
   typedef enum logic [2:0] {
      CLS_SAMPLE,
      CLS_TICK,
      CLS_RUN,
      CLS_SET_PUMP,
      CLS_SET_VALVE,
      CLS_TOGGLE_PUMP,
      CLS_TOGGLE_VALVE,
      CLS_NONE
   } cls_type;

   // occlusion sequencer
   typedef enum logic [2:0] {
      SEQ_IDLE    = 3'b001,
      SEQ_INFLATE = 3'b010,
      SEQ_HOLD    = 3'b100
   } seq_type;

   // back-end control
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MUL   = 6'b000010,
      ST_CONV  = 6'b000100,
      ST_SEQ   = 6'b001000,
      ST_SCALE = 6'b010000,
      ST_OUT   = 6'b100000
   } back_state_type;

   typedef struct packed {
      logic [2:0]                    op;
      logic signed [SAMPLE_BITS-1:0] raw_sample;
      logic                          level;
   } req_type;

   typedef struct packed {
      logic        pump_on;
      logic        valve_closed;
      logic [1:0]  phase;
      logic        run_active;
      logic [30:0] pressure_value;
      logic [15:0] pressure_mmhg;
      logic        over_limit;
   } rsp_type;

   typedef struct packed {
      cls_type                       cls;
      logic signed [SAMPLE_BITS-1:0] raw_sample;
      logic                          level;
   } cmd_type;

   // queue handshake between front and back
   typedef struct packed {
      logic ready;   // a command waits at the queue head
   } cmd_status_type;

   typedef struct packed {
      logic pop;     // back end takes the head command
   } cmd_ctrl_type;

endpackage

// File: design/coc_front.sv
// ----------------------------------------------------------------------------
// coc_front
// Input side: takes request words, classifies the op and holds the decoded
// commands in a short queue for the back end.
// ----------------------------------------------------------------------------
module coc_front import coc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_push,
   output logic           req_full,
   input  req_type        req_data,
   output cmd_status_type cmd_status,
   input  cmd_ctrl_type   cmd_ctrl,
   output cmd_type        cmd_word
);

   cmd_type              cmd_mem_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0] count_ff, count_in;
   logic                 push_ok;
   cls_type              cls;
   cmd_type              new_cmd;

   // op decode
   always_comb begin
      unique case (req_data.op)
         OP_SAMPLE:       cls = CLS_SAMPLE;
         OP_TICK:         cls = CLS_TICK;
         OP_RUN:          cls = CLS_RUN;
         OP_SET_PUMP:     cls = CLS_SET_PUMP;
         OP_SET_VALVE:    cls = CLS_SET_VALVE;
         OP_TOGGLE_PUMP:  cls = CLS_TOGGLE_PUMP;
         OP_TOGGLE_VALVE: cls = CLS_TOGGLE_VALVE;
         default:         cls = CLS_NONE;
      endcase
   end

   assign new_cmd.cls        = cls;
   assign new_cmd.raw_sample = req_data.raw_sample;
   assign new_cmd.level      = req_data.level;

   assign req_full = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign push_ok  = req_push && !req_full;

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_ctrl.pop) begin
         rd_ptr_in = (rd_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !cmd_ctrl.pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_ok && cmd_ctrl.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         cmd_mem_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   assign cmd_status.ready = (count_ff != '0);
   assign cmd_word         = cmd_mem_ff[rd_ptr_ff];

endmodule

// File: design/coc_back.sv
// ----------------------------------------------------------------------------
// coc_back
// Execution side: holds the registers and the control state, converts
// samples through one shared multiplier, steps the occlusion sequencer and
// keeps the result word until it is taken.
// ----------------------------------------------------------------------------
module coc_back import coc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_we,
   input  logic [2:0]     csr_index,
   input  logic [31:0]    csr_wdata,
   input  cmd_status_type cmd_status,
   output cmd_ctrl_type   cmd_ctrl,
   input  cmd_type        cmd_word,
   output logic           rsp_empty,
   input  logic           rsp_pop,
   output rsp_type        rsp_data
);

   back_state_type state_ff, state_in;

   // registers
   logic signed [31:0] gain_ff, gain_in;
   logic signed [31:0] offset_ff, offset_in;
   logic [30:0]        max_ff, max_in;
   logic [30:0]        cap_ff, cap_in;
   logic [7:0]         hold_sec_ff, hold_sec_in;
   logic [15:0]        factor_ff, factor_in;

   // controller state
   logic               pump_ff, pump_in;
   logic               valve_ff, valve_in;
   logic               run_ff, run_in;
   seq_type            seq_ff, seq_in;
   logic [7:0]         hold_ff, hold_in;
   logic signed [31:0] press_ff, press_in;
   logic               limit_ff, limit_in;

   // datapath
   cmd_type            cmd_ff;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic signed [47:0] scaled;
   logic signed [48:0] diff;
   logic [31:0]        press_sat;
   logic [30:0]        press_clamp;
   logic               over;
   logic [15:0]        mmhg;
   logic [1:0]         phase_code;
   logic               rsp_load;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_word;

   // register writes
   always_comb begin
      gain_in     = gain_ff;
      offset_in   = offset_ff;
      max_in      = max_ff;
      cap_in      = cap_ff;
      hold_sec_in = hold_sec_ff;
      factor_in   = factor_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CONV_GAIN:    gain_in     = signed'(csr_wdata);
            CSR_CONV_OFFSET:  offset_in   = signed'(csr_wdata);
            CSR_MAX_PRESSURE: max_in      = csr_wdata[30:0];
            CSR_PRESSURE_CAP: cap_in      = csr_wdata[30:0];
            CSR_HOLD_SECONDS: hold_sec_in = csr_wdata[7:0];
            CSR_MMHG_FACTOR:  factor_in   = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // pressure as reported: negative shown as zero
   assign press_clamp = press_ff[31] ? '0 : press_ff[30:0];
   assign over        = !press_ff[31] && (press_ff[30:0] >= max_ff);

   // shared multiplier: gain x sample, then pressure x mmHg factor
   always_comb begin
      if (state_ff == ST_MUL) begin
         mul_a = gain_ff;
         mul_b = MUL_W'(cmd_ff.raw_sample);
      end else begin
         mul_a = signed'({1'b0, press_clamp});
         mul_b = signed'({{(MUL_W - 16){1'b0}}, factor_ff});
      end
   end
   assign prod_in = mul_a * mul_b;

   // floor of the Q16 product, offset removed, saturated to 32 bits
   assign scaled = prod_ff[63:16];
   assign diff   = {scaled[47], scaled} - {{17{offset_ff[31]}}, offset_ff};
   always_comb begin
      if (diff[48:31] == {18{diff[48]}}) begin
         press_sat = diff[31:0];
      end else begin
         press_sat = diff[48] ? PRESS_NEG_SAT : PRESS_POS_SAT;
      end
   end

   // mmHg from the second product, saturated
   assign mmhg = (prod_ff[46:32] != '0) ? MMHG_SAT : prod_ff[31:16];

   always_comb begin
      unique case (seq_ff)
         SEQ_IDLE:    phase_code = PHASE_IDLE;
         SEQ_INFLATE: phase_code = PHASE_INFLATE;
         SEQ_HOLD:    phase_code = PHASE_HOLD;
         default:     phase_code = PHASE_IDLE;
      endcase
   end

   // command execution: drive and run settings, safety check, hold count and sequencer step
   always_comb begin
      pump_in  = pump_ff;
      valve_in = valve_ff;
      run_in   = run_ff;
      seq_in   = seq_ff;
      hold_in  = hold_ff;
      limit_in = limit_ff;
      if (state_ff == ST_SEQ) begin
         unique case (cmd_ff.cls)
            CLS_RUN:          run_in   = cmd_ff.level;
            CLS_SET_PUMP:     pump_in  = cmd_ff.level;
            CLS_SET_VALVE:    valve_in = cmd_ff.level;
            CLS_TOGGLE_PUMP:  pump_in  = !pump_ff;
            CLS_TOGGLE_VALVE: valve_in = !valve_ff;
            CLS_NONE: ;
            CLS_SAMPLE, CLS_TICK: begin
               if (cmd_ff.cls == CLS_SAMPLE) begin
                  limit_in = over;
                  if (over) begin
                     pump_in  = 1'b0;
                     valve_in = 1'b0;
                  end
               end else if (seq_ff == SEQ_HOLD && hold_ff != HOLD_SAT) begin
                  hold_in = hold_ff + 1'b1;
               end
               if (!run_ff) begin
                  valve_in = 1'b0;
               end else begin
                  if (seq_in == SEQ_IDLE && press_clamp < cap_ff) begin
                     valve_in = 1'b1;
                     pump_in  = 1'b1;
                     seq_in   = SEQ_INFLATE;
                  end
                  if (seq_in == SEQ_INFLATE && press_clamp >= cap_ff) begin
                     pump_in = 1'b0;
                     hold_in = '0;
                     seq_in  = SEQ_HOLD;
                  end
                  if (seq_in == SEQ_HOLD && hold_in >= hold_sec_ff) begin
                     valve_in = 1'b0;
                     run_in   = 1'b0;
                     seq_in   = SEQ_IDLE;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign press_in = (state_ff == ST_CONV) ? signed'(press_sat) : press_ff;

   // result word
   assign rsp_word.pump_on        = pump_ff;
   assign rsp_word.valve_closed   = valve_ff;
   assign rsp_word.phase          = phase_code;
   assign rsp_word.run_active     = run_ff;
   assign rsp_word.pressure_value = press_clamp;
   assign rsp_word.pressure_mmhg  = mmhg;
   assign rsp_word.over_limit     = limit_ff;

   assign rsp_load     = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_pop);
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_pop ? 1'b0 : rsp_valid_ff);

   // control sequence per command
   always_comb begin
      state_in     = state_ff;
      cmd_ctrl.pop = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_status.ready) begin
               cmd_ctrl.pop = 1'b1;
               state_in     = (cmd_word.cls == CLS_SAMPLE) ? ST_MUL : ST_SEQ;
            end
         end
         ST_MUL:   state_in = ST_CONV;
         ST_CONV:  state_in = ST_SEQ;
         ST_SEQ:   state_in = ST_SCALE;
         ST_SCALE: state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gain_ff      <= 32'sd65536;
         offset_ff    <= '0;
         max_ff       <= 31'd40000;
         cap_ff       <= '0;
         hold_sec_ff  <= '0;
         factor_ff    <= 16'd492;
         pump_ff      <= 1'b0;
         valve_ff     <= 1'b0;
         run_ff       <= 1'b0;
         seq_ff       <= SEQ_IDLE;
         hold_ff      <= '0;
         press_ff     <= '0;
         limit_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_ff      <= gain_in;
         offset_ff    <= offset_in;
         max_ff       <= max_in;
         cap_ff       <= cap_in;
         hold_sec_ff  <= hold_sec_in;
         factor_ff    <= factor_in;
         pump_ff      <= pump_in;
         valve_ff     <= valve_in;
         run_ff       <= run_in;
         seq_ff       <= seq_in;
         hold_ff      <= hold_in;
         press_ff     <= press_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd_ctrl.pop) begin
         cmd_ff <= cmd_word;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_word;
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // a sample at the limit leaves both drives off, unless an idle run starts
   // inflating on the same step
   a_limit_forces_off: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEQ && cmd_ff.cls == CLS_SAMPLE && over
       && (!run_ff || seq_ff != SEQ_IDLE))
      |=> (!pump_ff && !valve_ff && limit_ff))
      else $error("drives not forced off at pressure limit");

   // an inactive run opens the valve on every sample or tick sequencer step
   a_idle_run_opens_valve: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEQ && !run_ff
       && (cmd_ff.cls == CLS_SAMPLE || cmd_ff.cls == CLS_TICK))
      |=> !valve_ff)
      else $error("valve left closed with run inactive");

   // a result that is loaded is there for the consumer next cycle
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (!rsp_empty && state_ff == ST_IDLE))
      else $error("result word not presented after load");
`endif

endmodule

// File: design/cuff_occlusion_controller.sv
// ----------------------------------------------------------------------------
// cuff_occlusion_controller
// Pump and valve controller for a blood-pressure cuff with load-cell
// pressure conversion, safety cut-off and a timed occlusion sequencer.
// ----------------------------------------------------------------------------
// Each request word gives one result word, in order. A sample word goes
// through queue pop, gain multiply, offset and saturation, safety check and
// sequencer step, mmHg multiply and result load; other words skip the gain
// multiply and offset steps. Result load waits for a free or popped result
// register. Both multiplies share one 32x32 multiplier. A two-word command
// queue takes new requests while the back end works and a one-word result
// register holds the answer until it is popped. The user must write registers
// through the csr_ port while the block is idle; nothing enforces it.
module cuff_occlusion_controller import coc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cmd_status_type cmd_status;
   cmd_ctrl_type   cmd_ctrl;
   cmd_type        cmd_word;

   coc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .cmd_status (cmd_status),
      .cmd_ctrl   (cmd_ctrl),
      .cmd_word   (cmd_word)
   );

   coc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd_status (cmd_status),
      .cmd_ctrl   (cmd_ctrl),
      .cmd_word   (cmd_word),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule
